/* hw/rtl/ssd_pkg.sv */
// Shared types, constants and glyph tables of the seven-segment display driver.
`timescale 1ns / 1ps

package ssd_pkg;

  // Default number of display digits for the DIGIT_COUNT parameter.
  localparam int unsigned DefDigitCount = 4;

  localparam int unsigned NumWidth  = 16;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned SegWidth  = 7;
  localparam int unsigned SelWidth  = 3;
  localparam int unsigned TextChars = 4;

  // Reciprocal of ten, exact for every 16-bit value: x / 10 == (x * Recip10) >> Recip10Shift.
  localparam logic [NumWidth-1:0] Recip10      = 16'hCCCD;
  localparam int unsigned         Recip10Shift = 19;

  localparam logic [SegWidth-1:0] SegBlank = 7'h00;
  localparam logic [SegWidth-1:0] SegAdg   = 7'h49;

  typedef enum logic [1:0] {
    OP_NUMBER = 2'd0,
    OP_TEXT   = 2'd1,
    OP_OFF    = 2'd2,
    OP_TEST   = 2'd3
  } op_e;

  // Handshake between the digit pipeline and the result sequencer.
  typedef struct packed {
    logic valid;
    op_e  op;
  } pipe_ctl_t;

  function automatic logic [SegWidth-1:0] digit_glyph(input logic [3:0] d);
    logic [SegWidth-1:0] g;
    case (d)
      4'd0:    g = 7'h3F;
      4'd1:    g = 7'h06;
      4'd2:    g = 7'h5B;
      4'd3:    g = 7'h4F;
      4'd4:    g = 7'h66;
      4'd5:    g = 7'h6D;
      4'd6:    g = 7'h7D;
      4'd7:    g = 7'h07;
      4'd8:    g = 7'h7F;
      4'd9:    g = 7'h6F;
      default: g = SegBlank;
    endcase
    return g;
  endfunction

  function automatic logic [SegWidth-1:0] char_glyph(input logic [CharWidth-1:0] c);
    logic [SegWidth-1:0] g;
    case (c)
      8'h20:   g = SegBlank;  // space
      8'h42:   g = 7'h7C;     // B
      8'h45:   g = 7'h79;     // E
      8'h49:   g = 7'h30;     // I
      8'h52:   g = 7'h50;     // R
      default: g = SegAdg;
    endcase
    return g;
  endfunction

endpackage

/* hw/rtl/ssd_if.sv */
// Valid/ready channel interfaces for display commands and digit strobes.
`timescale 1ns / 1ps

interface ssd_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [ssd_pkg::NumWidth-1:0]   number;
  logic [ssd_pkg::CharWidth-1:0]  char_first;
  logic [ssd_pkg::CharWidth-1:0]  char_second;
  logic [ssd_pkg::CharWidth-1:0]  char_third;
  logic [ssd_pkg::CharWidth-1:0]  char_fourth;

  modport source (
    output valid, operation, number, char_first, char_second, char_third, char_fourth,
    input  ready
  );
  modport sink (
    input  valid, operation, number, char_first, char_second, char_third, char_fourth,
    output ready
  );
endinterface

interface ssd_out_if;
  logic                          valid;
  logic                          ready;
  logic [ssd_pkg::SelWidth-1:0]  digit_select;
  logic [ssd_pkg::SegWidth-1:0]  segments;
  logic                          last_of_run;

  modport source (
    output valid, digit_select, segments, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, digit_select, segments, last_of_run,
    output ready
  );
endinterface

/* hw/rtl/ssd_pipe.sv */
// Stalling pipeline: input stage, one divide-by-ten stage per digit, glyph stage.
`timescale 1ns / 1ps

module ssd_pipe #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DefDigitCount
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ssd_pkg::op_e                     op_i,
  input  logic [ssd_pkg::NumWidth-1:0]     number_i,
  input  logic [ssd_pkg::CharWidth-1:0]    chars_i [ssd_pkg::TextChars],
  output ssd_pkg::pipe_ctl_t               ctl_o,
  input  logic                             ready_i,
  output logic [ssd_pkg::SegWidth-1:0]     pat_o [DIGIT_COUNT]
);

  localparam int unsigned NS = DIGIT_COUNT + 2;  // stage 0, DIGIT_COUNT dividers, glyph

  logic                           v_q   [NS];
  logic                           rdy   [NS];
  ssd_pkg::op_e                   op_q  [NS];
  logic [ssd_pkg::NumWidth-1:0]   x_q   [DIGIT_COUNT];
  logic [ssd_pkg::CharWidth-1:0]  ch_q  [DIGIT_COUNT+1][ssd_pkg::TextChars];
  logic [3:0]                     dg_q  [DIGIT_COUNT][DIGIT_COUNT];
  logic [ssd_pkg::SegWidth-1:0]   pat_q [DIGIT_COUNT];

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    if (k == NS - 1) begin : g_last
      assign rdy[k] = !v_q[k] || ready_i;
    end else begin : g_mid
      assign rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_ready_o = rdy[0];

  // valid bits
  for (genvar k = 0; k < NS; k++) begin : g_valid
    if (k == 0) begin : g_head
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= in_valid_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (rdy[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: capture
  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      op_q[0] <= op_i;
      x_q[0]  <= number_i;
      ch_q[0] <= chars_i;
    end
  end

  // stages 1..DIGIT_COUNT: stage k peels off digit DIGIT_COUNT-k
  for (genvar k = 1; k <= DIGIT_COUNT; k++) begin : g_div
    logic [2*ssd_pkg::NumWidth-1:0] prod;
    logic [12:0]                    quo;
    logic [ssd_pkg::NumWidth-1:0]   rem;
    logic [3:0]                     row [DIGIT_COUNT];

    assign prod = x_q[k-1] * ssd_pkg::Recip10;
    assign quo  = prod[2*ssd_pkg::NumWidth-1:ssd_pkg::Recip10Shift];
    assign rem  = x_q[k-1] - {quo, 3'b000} - {2'b00, quo, 1'b0};

    for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_row
      if (j == DIGIT_COUNT - k) begin : g_new
        assign row[j] = rem[3:0];
      end else if (k == 1) begin : g_zero
        assign row[j] = 4'd0;
      end else begin : g_copy
        assign row[j] = dg_q[k-2][j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        op_q[k]   <= op_q[k-1];
        ch_q[k]   <= ch_q[k-1];
        dg_q[k-1] <= row;
      end
    end

    if (k < DIGIT_COUNT) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[k]) begin
          x_q[k] <= {3'b000, quo};
        end
      end
    end
  end

  // glyph stage
  for (genvar j = 0; j < DIGIT_COUNT; j++) begin : g_glyph
    logic [ssd_pkg::SegWidth-1:0] txt;
    logic [ssd_pkg::SegWidth-1:0] gl;

    if (j < ssd_pkg::TextChars) begin : g_ch
      assign txt = ssd_pkg::char_glyph(ch_q[DIGIT_COUNT][j]);
    end else begin : g_blank
      assign txt = ssd_pkg::SegBlank;
    end

    always_comb begin
      case (op_q[DIGIT_COUNT])
        ssd_pkg::OP_NUMBER: gl = ssd_pkg::digit_glyph(dg_q[DIGIT_COUNT-1][j]);
        ssd_pkg::OP_TEXT:   gl = txt;
        default:            gl = ssd_pkg::SegBlank;
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (rdy[NS-1]) begin
        pat_q[j] <= gl;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS-1]) begin
      op_q[NS-1] <= op_q[DIGIT_COUNT];
    end
  end

  assign ctl_o.valid = v_q[NS-1];
  assign ctl_o.op    = op_q[NS-1];
  assign pat_o       = pat_q;

endmodule

/* hw/rtl/ssd_seq.sv */
// Result sequencer: turns one command into its digit strobes, with an output register.
`timescale 1ns / 1ps

module ssd_seq #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DefDigitCount
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssd_pkg::pipe_ctl_t             ctl_i,
  output logic                           ready_o,
  input  logic [ssd_pkg::SegWidth-1:0]   pat_i [DIGIT_COUNT],
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssd_pkg::SelWidth-1:0]   out_sel_o,
  output logic [ssd_pkg::SegWidth-1:0]   out_seg_o,
  output logic                           out_last_o
);

  localparam int unsigned CW = $clog2(DIGIT_COUNT + 1);
  localparam int unsigned IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  logic                          busy_q, busy_d;
  ssd_pkg::op_e                  op_q;
  logic [ssd_pkg::SegWidth-1:0]  pat_q [DIGIT_COUNT];
  logic [CW-1:0]                 dig_q, dig_d;
  logic [2:0]                    sg_q, sg_d;

  logic                          ov_q;
  logic [ssd_pkg::SelWidth-1:0]  osel_q;
  logic [ssd_pkg::SegWidth-1:0]  oseg_q;
  logic                          olast_q;

  logic                          load, emit, take;
  logic [CW:0]                   dig_inc;
  logic [ssd_pkg::SelWidth-1:0]  cur_sel;
  logic [ssd_pkg::SegWidth-1:0]  cur_seg;
  logic                          cur_last;

  assign load    = !ov_q || out_ready_i;
  assign emit    = busy_q && load;
  assign take    = !busy_q || (emit && cur_last);
  assign ready_o = take;
  assign dig_inc = {1'b0, dig_q} + (CW+1)'(1);

  // strobe for the current position
  always_comb begin
    cur_sel  = ssd_pkg::SelWidth'(dig_inc);
    cur_seg  = ssd_pkg::SegBlank;
    cur_last = 1'b0;
    case (op_q)
      ssd_pkg::OP_OFF: begin
        cur_sel  = '0;
        cur_last = 1'b1;
      end
      ssd_pkg::OP_TEST: begin
        if (dig_q == CW'(DIGIT_COUNT)) begin
          cur_sel  = '0;
          cur_last = 1'b1;
        end else begin
          cur_seg = ssd_pkg::SegWidth'(1) << sg_q;
        end
      end
      default: begin
        cur_seg  = pat_q[dig_q[IW-1:0]];
        cur_last = (dig_q == CW'(DIGIT_COUNT - 1));
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    busy_d = busy_q;
    dig_d  = dig_q;
    sg_d   = sg_q;
    if (emit) begin
      if (cur_last) begin
        busy_d = 1'b0;
      end else if (op_q == ssd_pkg::OP_TEST) begin
        if (sg_q == 3'd6) begin
          sg_d  = 3'd0;
          dig_d = dig_inc[CW-1:0];
        end else begin
          sg_d = sg_q + 3'd1;
        end
      end else begin
        dig_d = dig_inc[CW-1:0];
      end
    end
    if (take && ctl_i.valid) begin
      busy_d = 1'b1;
      dig_d  = '0;
      sg_d   = 3'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dig_q  <= '0;
      sg_q   <= 3'd0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      dig_q  <= dig_d;
      sg_q   <= sg_d;
      if (load) begin
        ov_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && ctl_i.valid) begin
      op_q  <= ctl_i.op;
      pat_q <= pat_i;
    end
    if (emit) begin
      osel_q  <= cur_sel;
      oseg_q  <= cur_seg;
      olast_q <= cur_last;
    end
  end

  assign out_valid_o = ov_q;
  assign out_sel_o   = osel_q;
  assign out_seg_o   = oseg_q;
  assign out_last_o  = olast_q;

`ifndef ASSERT_OFF
  a_sg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sg_q <= 3'd6)
    else $error("segment step out of range");

  a_dig_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (op_q == ssd_pkg::OP_NUMBER || op_q == ssd_pkg::OP_TEXT)
      |-> dig_q < CW'(DIGIT_COUNT))
    else $error("digit index past last digit");

  a_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && !cur_last |=> busy_q)
    else $error("command dropped before its last strobe");

  a_blank_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && olast_q && osel_q == '0 |-> oseg_q == ssd_pkg::SegBlank)
    else $error("closing strobe not blank");
`endif

endmodule

/* hw/rtl/seven_segment_display_driver_core.sv */
// Top level of the multiplexed seven-segment display driver.
`timescale 1ns / 1ps

// Usage:
//   in_i takes one display command per transaction: operation (number, text, off,
//   segment test), a 16-bit number and four characters. out_o gives digit strobes,
//   one per transaction: digit_select (0 none, 1 leftmost), segments (bit0 = A,
//   active high) and last_of_run on the final strobe of each command.
//   Number and text commands give DIGIT_COUNT strobes, off gives one blank strobe,
//   segment test gives 7 * DIGIT_COUNT + 1 strobes (29 at four digits).
// Path: a command passes a capture stage, DIGIT_COUNT divide-by-ten stages and a
//   glyph stage before the sequencer, which registers it and then puts its first
//   strobe into the output register.
// Throughput: the sequencer emits one strobe per cycle unless out_o stalls. Commands
//   enter the pipeline every cycle until it fills behind the sequencer.
// Reset (rst_ni, async, active low) empties the pipeline and the output register.
// A stall on out_o holds the strobe in the output register; the stall backs up
//   stage by stage, and in_i.ready drops only once every stage holds a command.

module seven_segment_display_driver_core #(
  parameter int unsigned DIGIT_COUNT = ssd_pkg::DefDigitCount
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_in_if.sink    in_i,
  ssd_out_if.source out_o
);

  logic [ssd_pkg::CharWidth-1:0] chars [ssd_pkg::TextChars];
  logic [ssd_pkg::SegWidth-1:0]  pat   [DIGIT_COUNT];
  ssd_pkg::pipe_ctl_t            ctl;
  ssd_pkg::op_e                  op;
  logic                          in_ready;
  logic                          seq_ready;

  // operation field maps one to one onto the command codes
  assign op       = ssd_pkg::op_e'(in_i.operation);
  assign chars[0] = in_i.char_first;
  assign chars[1] = in_i.char_second;
  assign chars[2] = in_i.char_third;
  assign chars[3] = in_i.char_fourth;

  ssd_pipe #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_pipe (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .op_i       (op),
    .number_i   (in_i.number),
    .chars_i    (chars),
    .ctl_o      (ctl),
    .ready_i    (seq_ready),
    .pat_o      (pat)
  );

  assign in_i.ready = in_ready;

  ssd_seq #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .ready_o     (seq_ready),
    .pat_i       (pat),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_sel_o   (out_o.digit_select),
    .out_seg_o   (out_o.segments),
    .out_last_o  (out_o.last_of_run)
  );

endmodule
